// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked every clock, masked while reset is asserted
`define SCR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked every clock, reset included
`define SCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/scr_pkg.sv =====
package scr_pkg;

    // Default coefficient count per polynomial
    localparam int POLY_COEFFS_DEF = 256;
    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Rejection limits
    localparam logic [6:0]  LIMIT_U2 = 7'd125;
    localparam logic [15:0] LIMIT_U4 = 16'd59049;

    // Digits per accepted value
    localparam logic [2:0] DIGITS_U2 = 3'd3;
    localparam logic [2:0] DIGITS_U4 = 3'd5;

    // Mode codes
    localparam logic MODE_U2 = 1'b0;
    localparam logic MODE_U4 = 1'b1;

    // Byte pairing phase
    localparam logic PHASE_HIGH = 1'b0;
    localparam logic PHASE_LOW  = 1'b1;

    // Reciprocal multipliers for divide by 5 (value < 125) and by 9 (value < 65536)
    localparam logic [16:0] RECIP_5 = 17'd205;
    localparam logic [16:0] RECIP_9 = 17'd58255;

    typedef logic signed [3:0] t_coef;

    // One accepted value waiting for digit extraction
    typedef struct packed {
        logic [15:0] val;
        logic        mode;
        logic [2:0]  ndig;
        logic        last;
    } t_entry;

endpackage

// ===== rtl/scr_ifs.sv =====
// Input byte channel
interface scr_in_if;
    import scr_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;
    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

// Coefficient output channel
interface scr_out_if;
    import scr_pkg::*;
    logic  valid;
    logic  ready;
    t_coef coefficient;
    logic  last;
    modport source (output valid, output coefficient, output last, input ready);
    modport sink   (input valid, input coefficient, input last, output ready);
endinterface

// Configuration write channel
interface scr_cfg_if;
    logic valid;
    logic ready;
    logic range_mode;
    modport source (output valid, output range_mode, input ready);
    modport sink   (input valid, input range_mode, output ready);
endinterface

// ===== rtl/scr_front.sv =====
module scr_front
    import scr_pkg::*;
#(
    parameter int POLY_COEFFS = POLY_COEFFS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scr_in_if.sink     i_byte,
    input  logic       i_range_mode,
    input  logic       i_full,
    output logic       o_push,
    output t_entry     o_entry
);

    localparam int CNT_W = $clog2(POLY_COEFFS + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_high, n_high;
    logic             r_phase, n_phase;

    logic             accept;
    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] rem;
    logic             phase_eff;
    logic [6:0]       v7;
    logic [15:0]      v16;
    logic [2:0]       nmax;
    logic [2:0]       nd;

    assign i_byte.ready = !i_full;
    assign accept       = i_byte.valid && !i_full;

    // start clears count and pairing before the byte is used
    assign cnt_eff   = i_byte.start_req ? '0 : r_cnt;
    assign phase_eff = i_byte.start_req ? PHASE_HIGH : r_phase;
    assign rem       = CNT_W'(POLY_COEFFS) - cnt_eff;
    assign v7        = i_byte.data_byte[7:1];
    assign v16       = {r_high, i_byte.data_byte};
    assign nmax      = (i_range_mode == MODE_U4) ? DIGITS_U4 : DIGITS_U2;
    // clip digit count at end of polynomial
    assign nd        = (32'(rem) < 32'(nmax)) ? 3'(rem) : nmax;

    // classify byte and build queue word
    always_comb begin
        n_cnt   = r_cnt;
        n_high  = r_high;
        n_phase = r_phase;
        o_push  = 1'b0;
        o_entry.mode = i_range_mode;
        o_entry.ndig = nd;
        o_entry.last = (32'(rem) <= 32'(nmax));
        o_entry.val  = (i_range_mode == MODE_U4) ? v16 : {9'd0, v7};
        if (accept) begin
            n_cnt   = cnt_eff;
            n_phase = phase_eff;
            if (cnt_eff < CNT_W'(POLY_COEFFS)) begin
                if (i_range_mode == MODE_U2) begin
                    if (v7 < LIMIT_U2) begin
                        o_push = 1'b1;
                        n_cnt  = cnt_eff + CNT_W'(nd);
                    end
                end else if (phase_eff == PHASE_HIGH) begin
                    n_high  = i_byte.data_byte;
                    n_phase = PHASE_LOW;
                end else begin
                    n_phase = PHASE_HIGH;
                    if (v16 < LIMIT_U4) begin
                        o_push = 1'b1;
                        n_cnt  = cnt_eff + CNT_W'(nd);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_high  <= '0;
            r_phase <= PHASE_HIGH;
        end else begin
            r_cnt   <= n_cnt;
            r_high  <= n_high;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== rtl/scr_queue.sv =====
module scr_queue
    import scr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage words
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

// ===== rtl/scr_back.sv =====
module scr_back
    import scr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_entry   i_q_head,
    output logic     o_pop,
    scr_out_if.source o_coef
);

    logic [15:0] r_val;
    logic        r_mode;
    logic        r_last;
    logic [2:0]  r_left;

    logic        r_ovalid;
    t_coef       r_ocoef;
    logic        r_olast;

    logic        busy, out_free, step, load;
    logic [32:0] prod;
    logic [15:0] quot;
    logic [15:0] qbase;
    logic [3:0]  digit;

    assign busy     = (r_left != '0);
    assign out_free = !r_ovalid || o_coef.ready;
    assign step     = busy && out_free;
    assign load     = i_q_valid && (!busy || (step && r_left == 3'd1));
    assign o_pop    = load;

    // one digit per cycle unless the output stalls: quotient by reciprocal multiply, remainder by shift-add
    assign prod  = r_val * ((r_mode == MODE_U4) ? RECIP_9 : RECIP_5);
    assign quot  = (r_mode == MODE_U4) ? 16'(prod >> 19) : 16'(prod >> 10);
    assign qbase = (r_mode == MODE_U4) ? ((quot << 3) + quot) : ((quot << 2) + quot);
    assign digit = 4'(r_val - qbase);

    // digit unit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (load) begin
            r_left <= i_q_head.ndig;
        end else if (step) begin
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_val  <= i_q_head.val;
            r_mode <= i_q_head.mode;
            r_last <= i_q_head.last;
        end else if (step) begin
            r_val  <= quot;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (step) begin
            r_ovalid <= 1'b1;
        end else if (o_coef.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_ocoef <= t_coef'(digit - ((r_mode == MODE_U4) ? 4'd4 : 4'd2));
            r_olast <= r_last && (r_left == 3'd1);
        end
    end

    assign o_coef.valid       = r_ovalid;
    assign o_coef.coefficient = r_ocoef;
    assign o_coef.last        = r_olast;

endmodule

// ===== rtl/small_coeff_rejection_sampler.sv =====
// Channel    Dir  Payload                          Notes
// i_byte     in   data_byte[7:0], start_req        stream bytes, start opens a polynomial
// o_coef     out  coefficient[3:0] signed, last    one coefficient per word
// i_cfg      in   range_mode                       always ready, write only when idle
//
// A byte is taken in the cycle it arrives whenever the queue has room; a rejected
// byte or a range-four high byte is consumed and yields nothing.
// The digit unit gives one coefficient per cycle (one reciprocal multiply) unless
// output stalls; a range-two byte yields up to 3, a range-four pair up to 5 coefficients.
// Synchronous reset clears count, pairing, queue, digit unit and output valid.
// Output stalls back up through the digit unit and queue to i_byte.ready.
module small_coeff_rejection_sampler
    import scr_pkg::*;
#(
    parameter int POLY_COEFFS = POLY_COEFFS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scr_in_if.sink    i_byte,
    scr_cfg_if.sink   i_cfg,
    scr_out_if.source o_coef
);

    logic   r_range_mode;
    logic   push, full, pop, q_valid;
    t_entry push_entry, q_head;

    // mode register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_mode <= MODE_U2;
        end else if (i_cfg.valid) begin
            r_range_mode <= i_cfg.range_mode;
        end
    end

    scr_front #(
        .POLY_COEFFS (POLY_COEFFS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .i_range_mode (r_range_mode),
        .i_full       (full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    scr_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    scr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_coef    (o_coef)
    );

endmodule

// ===== rtl/scr_checker.sv =====
`include "assert_macros.svh"

module scr_checker
    import scr_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_cfg_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_coef i_out_coef,
    input logic  i_out_last
);

    // a stalled word holds
    `SCR_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_coef) && $stable(i_out_last)), "output word changed while stalled")

    // coefficients stay in [-4,4]
    `SCR_ASSERT(a_coef_range, i_clk, i_rst_n, i_out_valid |-> (i_out_coef >= -4 && i_out_coef <= 4), "coefficient out of range")

    // reset empties the output register
    `SCR_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // configuration port never stalls
    `SCR_ASSERT(a_cfg_ready, i_clk, i_rst_n, i_cfg_ready, "configuration port not ready")

endmodule

bind small_coeff_rejection_sampler scr_checker u_scr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_ready (i_cfg.ready),
    .i_out_valid (o_coef.valid),
    .i_out_ready (o_coef.ready),
    .i_out_coef  (o_coef.coefficient),
    .i_out_last  (o_coef.last)
);

// ===== tb/scr_checker.sv =====
// Watches the byte, config and coefficient channels, predicts the coefficient
// stream and compares every accepted coefficient word against it.
module tb_scr_checker
    import scr_pkg::*;
#(
    parameter int POLY_COEFFS = POLY_COEFFS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    scr_in_if    i_byte,
    scr_cfg_if   i_cfg,
    scr_out_if   i_coef,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int BASE_U2   = 5;
    localparam int OFFSET_U2 = 2;
    localparam int BASE_U4   = 9;
    localparam int OFFSET_U4 = 4;

    typedef struct {
        t_coef coef;
        logic  last;
    } t_coef_word;

    // Predicted coefficient words, oldest first
    t_coef_word coef_q[$];

    // Predictor state
    int         poly_count;
    logic [7:0] held_high;
    logic       pair_phase;
    logic       cur_mode;
    int         fails = 0;

    // Split val into base digits, least significant first; stop at end of polynomial
    task automatic queue_digits(input int unsigned val, input int unsigned base,
                                input int unsigned offset, input logic [2:0] ndig);
        t_coef_word  w;
        int unsigned rest;
        rest = val;
        for (int j = 0; j < ndig; j++) begin
            poly_count++;
            w.coef = t_coef'((rest % base) - offset);
            w.last = (poly_count >= POLY_COEFFS);
            coef_q.push_back(w);
            rest = rest / base;
            if (w.last)
                break;
        end
    endtask

    // Coefficients caused by one accepted byte
    task automatic predict_byte(input logic [7:0] b, input logic s);
        logic [15:0] pair;
        if (s) begin
            poly_count = 0;
            pair_phase = PHASE_HIGH;
        end
        // polynomial complete: byte dropped, state untouched
        if (poly_count >= POLY_COEFFS)
            return;
        if (cur_mode == MODE_U2) begin
            if (b[7:1] < LIMIT_U2)
                queue_digits(b[7:1], BASE_U2, OFFSET_U2, DIGITS_U2);
        end else if (pair_phase == PHASE_HIGH) begin
            held_high  = b;
            pair_phase = PHASE_LOW;
        end else begin
            pair       = {held_high, b};
            pair_phase = PHASE_HIGH;
            if (pair < LIMIT_U4)
                queue_digits(pair, BASE_U4, OFFSET_U4, DIGITS_U4);
        end
    endtask

    always @(posedge i_clk) begin
        t_coef_word want;
        if (!i_rst_n) begin
            poly_count = 0;
            held_high  = '0;
            pair_phase = PHASE_HIGH;
            cur_mode   = MODE_U2;
            coef_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                cur_mode = i_cfg.range_mode;
            // bytes first, so a same-cycle word still finds its prediction
            if (i_byte.valid && i_byte.ready)
                predict_byte(i_byte.data_byte, i_byte.start_req);
            if (i_coef.valid && i_coef.ready) begin
                if (coef_q.size() == 0) begin
                    $display("%0t: unexpected coefficient word: coef %0d last %0b",
                             $time, i_coef.coefficient, i_coef.last);
                    fails++;
                end else begin
                    want = coef_q.pop_front();
                    if (i_coef.coefficient !== want.coef) begin
                        $display("%0t: coefficient mismatch: expected %0d, actual %0d",
                                 $time, want.coef, i_coef.coefficient);
                        fails++;
                    end
                    if (i_coef.last !== want.last) begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, i_coef.last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= coef_q.size();
    end

endmodule

// ===== tb/tb_small_coeff_rejection_sampler.sv =====
// Stimulus and verdict; prediction and checks live in tb_scr_checker.
module tb_small_coeff_rejection_sampler;
    import scr_pkg::*;

    localparam int POLY      = POLY_COEFFS_DEF;
    localparam int SETTLE    = 20;      // covers queue plus digit unit
    localparam int MAX_CYC   = 400000;
    localparam int PHASE_LEN = 20;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_pct;
    int   stall_pct;

    scr_in_if  byte_ch ();
    scr_cfg_if cfg_ch ();
    scr_out_if coef_ch ();

    small_coeff_rejection_sampler #(.POLY_COEFFS(POLY)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_byte (byte_ch),
        .i_cfg  (cfg_ch),
        .o_coef (coef_ch)
    );

    tb_scr_checker #(.POLY_COEFFS(POLY)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (byte_ch),
        .i_cfg       (cfg_ch),
        .i_coef      (coef_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Coefficient receiver with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n)
            coef_ch.ready <= 1'b0;
        else
            coef_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop
    initial begin
        repeat (MAX_CYC) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // One byte word, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic s);
        while ($urandom_range(99) < idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.start_req <= s;
        do @(posedge i_clk); while (!byte_ch.ready);
    endtask

    // Hold off until every predicted word is out and the block has settled;
    // first let the edge of the last accepted byte pass so the count includes it
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.range_mode <= m;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly uniform, with the range-two reject band weighted up
    function automatic logic [7:0] rand_byte();
        if ($urandom_range(99) < 8)
            return 8'($urandom_range(255, 250));
        return 8'($urandom_range(255));
    endfunction

    initial begin
        int idle_tab [4];
        int stall_tab[4];
        logic mode_tab[4];
        int sent;
        int len;
        logic m;

        idle_tab  = '{0, 64, 0, 31};
        stall_tab = '{0, 0, 64, 31};
        mode_tab  = '{MODE_U4, MODE_U2, MODE_U4, MODE_U2};

        i_rst_n           <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.start_req <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.range_mode <= MODE_U2;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Range-two edges: all-low digits, all-high digits, reject band
        write_mode(MODE_U2);
        send_byte(8'h00, 1'b1);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hF9, 1'b0);
        send_byte(8'hFA, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        wait_idle();

        // Range-four edges: zero pair, largest kept pair, first rejected pair
        write_mode(MODE_U4);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hE6, 1'b0);
        send_byte(8'hA8, 1'b0);
        send_byte(8'hE6, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);

        // High byte stays pending across range-two bytes
        send_byte(8'h12, 1'b0);
        wait_idle();
        write_mode(MODE_U2);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        wait_idle();
        write_mode(MODE_U4);
        send_byte(8'h34, 1'b0);

        // Start mid-pair drops the pending high byte
        send_byte(8'hAB, 1'b0);
        send_byte(8'hCD, 1'b1);
        send_byte(8'h00, 1'b0);
        wait_idle();

        // Random polynomials, some long enough to run off the end
        for (int ph = 0; ph < 4; ph++) begin
            m = mode_tab[ph];
            write_mode(m);
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            sent = 0;
            while (sent < PHASE_LEN) begin
                if ($urandom_range(99) < 40)
                    len = (m == MODE_U4) ? 124 : 92;
                else
                    len = $urandom_range(24, 1);
                for (int k = 0; k < len; k++) begin
                    send_byte(rand_byte(), (k == 0) || ($urandom_range(99) < 2));
                    sent++;
                end
                // in the last phase the sender holds off once mid-phase until the output drains
                if (ph == 3 && sent >= PHASE_LEN / 2 && sent - len < PHASE_LEN / 2)
                    wait_idle();
            end
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
